// File: rtl/first_fit_waitlist_queue_macros.svh
// assertion helpers for the waitlist queue
`ifndef FIRST_FIT_WAITLIST_QUEUE_MACROS_SVH
`define FIRST_FIT_WAITLIST_QUEUE_MACROS_SVH

// same-cycle implication, off while in reset
`define FFWQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffwq assertion failed");

// next-cycle implication, off while in reset
`define FFWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffwq assertion failed");

`endif

// File: rtl/ffwq_pkg.sv
`default_nettype none

package ffwq_pkg;

   typedef struct packed {
      logic [63:0] word0;
      logic [63:0] word1;
      logic [31:0] word2;
      logic [7:0]  size;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic wrap;
      logic load;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LIST   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_ADDED   = 3'd0,
      STAT_DUP     = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_ENTRY   = 3'd3,
      STAT_REMOVED = 3'd4,
      STAT_NONE    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

endpackage

`default_nettype wire

// File: rtl/ffwq_cell.sv
`default_nettype none

module ffwq_cell (
   input  wire logic                 clock,
   input  wire ffwq_pkg::cell_ctl_type ctl,
   input  wire ffwq_pkg::entry_type  next_entry,
   input  wire ffwq_pkg::entry_type  head_entry,
   input  wire ffwq_pkg::entry_type  load_entry,
   output ffwq_pkg::entry_type       entry_q
);
   import ffwq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = load_entry;
      end else if (ctl.shift) begin
         // the tail of the occupied run takes the head back during a rotation
         entry_in = ctl.wrap ? head_entry : next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

`default_nettype wire

// File: rtl/first_fit_waitlist_queue.sv
// first_fit_waitlist_queue: ordered waiting list of up to DEPTH named entries.
// request channel (req_*): operation, 20-byte key, group size and size limit;
// accepted at a clock edge where req_valid is high and req_stall is low.
// response channel (rsp_*): status, entry name and size, and rsp_last on the
// final response of a request; taken where rsp_valid is high and rsp_stall low.
// entries sit in a row of cells in arrival order. every request rotates the
// occupied cells once around, one cell per cycle unless the response is stalled, looking at the head cell:
// add checks names there, remove drops the first fitting head, list and search
// report heads. a request goes through accept, one rotation step per stored entry,
// end of scan and final response; one request is worked on at a time and req_stall is
// high until it completes. list and search hold one entry back so rsp_last
// can mark the true final response. a stalled response holds its register and
// freezes the rotation. synchronous reset empties the list and drops any
// pending response; entry contents are not cleared.
`default_nettype none

`include "first_fit_waitlist_queue_macros.svh"

module first_fit_waitlist_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [63:0] req_key_word0,
   input  wire logic [63:0] req_key_word1,
   input  wire logic [31:0] req_key_word2,
   input  wire logic [7:0]  req_group_size,
   input  wire logic [7:0]  req_size_limit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_out_word0,
   output logic [63:0]      rsp_out_word1,
   output logic [31:0]      rsp_out_word2,
   output logic [7:0]       rsp_out_size,
   output logic             rsp_last
);
   import ffwq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   entry_type  key_ff, key_in;
   logic [7:0] lim_ff, lim_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] step_ff, step_in;

   logic       dup_ff, dup_in;
   logic       found_ff, found_in;
   entry_type  pend_ff, pend_in;
   logic       pend_vld_ff, pend_vld_in;

   logic       rsp_vld_ff, rsp_vld_in;
   status_type rsp_status_ff, rsp_status_in;
   entry_type  rsp_entry_ff, rsp_entry_in;
   logic       rsp_last_ff, rsp_last_in;

   logic do_rotate, do_drop, do_load;
   logic out_free, fits, key_hit;

   entry_type cell_q [DEPTH];
   entry_type head;

   assign head     = cell_q[0];
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign fits     = head.size <= lim_ff;
   assign key_hit  = (head.word0 == key_ff.word0) && (head.word1 == key_ff.word1) &&
                     (head.word2 == key_ff.word2);

   // row of storage cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    nbr;

      assign ctl.shift = (do_rotate || do_drop) && (CNT_W'(i) < count_ff);
      assign ctl.wrap  = do_rotate && (count_ff == CNT_W'(i + 1));
      assign ctl.load  = do_load && (count_ff == CNT_W'(i));

      if (i < DEPTH - 1) begin : g_mid
         assign nbr = cell_q[i + 1];
      end else begin : g_end
         assign nbr = cell_q[0];
      end

      ffwq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .next_entry (nbr),
         .head_entry (head),
         .load_entry (key_ff),
         .entry_q    (cell_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      lim_in        = lim_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      step_in       = step_ff;
      dup_in        = dup_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      do_rotate     = 1'b0;
      do_drop       = 1'b0;
      do_load       = 1'b0;

      if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = op_type'(req_operation);
               key_in.word0 = req_key_word0;
               key_in.word1 = req_key_word1;
               key_in.word2 = req_key_word2;
               key_in.size  = req_group_size;
               lim_in       = req_size_limit;
               total_in     = count_ff;
               step_in      = '0;
               dup_in       = 1'b0;
               found_in     = 1'b0;
               pend_vld_in  = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == total_ff) begin
               state_in = ST_FINISH;
            end else if (out_free) begin
               step_in = step_ff + CNT_W'(1);
               case (op_ff)
                  OP_ADD: begin
                     if (key_hit) begin
                        dup_in = 1'b1;
                     end
                     do_rotate = 1'b1;
                  end
                  OP_REMOVE: begin
                     // drop the head without wrap; later rotations restore order
                     if (!found_ff && fits) begin
                        do_drop     = 1'b1;
                        found_in    = 1'b1;
                        pend_in     = head;
                        pend_vld_in = 1'b1;
                        count_in    = count_ff - CNT_W'(1);
                     end else begin
                        do_rotate = 1'b1;
                     end
                  end
                  default: begin
                     do_rotate = 1'b1;
                     if (op_ff == OP_LIST || fits) begin
                        // release the held entry, hold this one
                        if (pend_vld_ff) begin
                           rsp_vld_in    = 1'b1;
                           rsp_status_in = STAT_ENTRY;
                           rsp_entry_in  = pend_ff;
                           rsp_last_in   = 1'b0;
                        end
                        pend_in     = head;
                        pend_vld_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
               if (op_ff == OP_ADD) begin
                  rsp_entry_in = key_ff;
                  if (dup_ff) begin
                     rsp_status_in = STAT_DUP;
                  end else if (count_ff == CNT_W'(DEPTH)) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_status_in = STAT_ADDED;
                     do_load       = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (pend_vld_ff) begin
                  rsp_status_in = (op_ff == OP_REMOVE) ? STAT_REMOVED : STAT_ENTRY;
                  rsp_entry_in  = pend_ff;
               end else begin
                  rsp_status_in = STAT_NONE;
                  rsp_entry_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lim_ff        <= lim_in;
      total_ff      <= total_in;
      step_ff       <= step_in;
      dup_ff        <= dup_in;
      found_ff      <= found_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_vld_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_word0 = rsp_entry_ff.word0;
   assign rsp_out_word1 = rsp_entry_ff.word1;
   assign rsp_out_word2 = rsp_entry_ff.word2;
   assign rsp_out_size  = rsp_entry_ff.size;
   assign rsp_last      = rsp_last_ff;

   `FFWQ_ASSERT_IMPLY(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `FFWQ_ASSERT_IMPLY(a_step_bound, clock, reset, state_ff == ST_SCAN, step_ff <= total_ff)
   `FFWQ_ASSERT_IMPLY(a_one_remove, clock, reset,
      (state_ff != ST_IDLE) && (op_ff == OP_REMOVE) && found_ff,
      count_ff == total_ff - CNT_W'(1))
   `FFWQ_ASSERT_NEXT(a_grow_on_add, clock, reset,
      (state_ff == ST_FINISH) && out_free && (op_ff == OP_ADD) && !dup_ff &&
      (count_ff != CNT_W'(DEPTH)),
      rsp_valid && (rsp_status == STAT_ADDED))

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import ffwq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 48;
   localparam int POOL_SIZE   = 24;

   typedef struct {
      status_type status;
      entry_type  ent;
      logic       last;
   } response_type;

   class waitlist_scoreboard;
      entry_type    waitlist[$];
      response_type expected[$];
      int           errors = 0;

      function int pending();
         return expected.size();
      endfunction

      // works out the responses of one accepted transaction
      function void note_request(op_type op, entry_type item, logic [7:0] limit);
         response_type r;
         int           hits[$];
         r.status = STAT_NONE;
         r.ent    = '0;
         r.last   = 1'b1;
         case (op)
            OP_ADD: begin
               r.status = STAT_ADDED;
               r.ent    = item;
               foreach (waitlist[i]) begin
                  if ({waitlist[i].word0, waitlist[i].word1, waitlist[i].word2} ==
                      {item.word0, item.word1, item.word2})
                     r.status = STAT_DUP;
               end
               // name check wins over the full check
               if (r.status == STAT_ADDED && waitlist.size() >= DEPTH)
                  r.status = STAT_FULL;
               if (r.status == STAT_ADDED)
                  waitlist.push_back(item);
               expected.push_back(r);
            end
            OP_REMOVE: begin
               foreach (waitlist[i]) begin
                  if (hits.size() == 0 && waitlist[i].size <= limit)
                     hits.push_back(i);
               end
               if (hits.size() != 0) begin
                  r.status = STAT_REMOVED;
                  r.ent    = waitlist[hits[0]];
                  waitlist.delete(hits[0]);
               end
               expected.push_back(r);
            end
            default: begin
               foreach (waitlist[i]) begin
                  if (op == OP_LIST || waitlist[i].size <= limit)
                     hits.push_back(i);
               end
               foreach (hits[k]) begin
                  r.status = STAT_ENTRY;
                  r.ent    = waitlist[hits[k]];
                  r.last   = (k == hits.size() - 1);
                  expected.push_back(r);
               end
               if (hits.size() == 0)
                  expected.push_back(r);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [2:0] status, entry_type ent, logic last);
         response_type want;
         if (expected.size() == 0) begin
            $error("response with status %0d while none was expected", status);
            errors++;
            return;
         end
         want = expected.pop_front();
         compare_field("status", want.status, status);
         compare_field("out_word0", want.ent.word0, ent.word0);
         compare_field("out_word1", want.ent.word1, ent.word1);
         compare_field("out_word2", want.ent.word2, ent.word2);
         compare_field("out_size", want.ent.size, ent.size);
         compare_field("last", want.last, last);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [63:0] req_key_word0;
   logic [63:0] req_key_word1;
   logic [31:0] req_key_word2;
   logic [7:0]  req_group_size;
   logic [7:0]  req_size_limit;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_out_word0;
   logic [63:0] rsp_out_word1;
   logic [31:0] rsp_out_word2;
   logic [7:0]  rsp_out_size;
   logic        rsp_last;

   waitlist_scoreboard sb;
   int req_idle_pct = 20;
   int rsp_idle_pct = 20;
   bit hold_rsp     = 1'b0;
   int quiet_cycles = 0;

   first_fit_waitlist_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key_word0 (req_key_word0),
      .req_key_word1 (req_key_word1),
      .req_key_word2 (req_key_word2),
      .req_group_size(req_group_size),
      .req_size_limit(req_size_limit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_word0 (rsp_out_word0),
      .rsp_out_word1 (rsp_out_word1),
      .rsp_out_word2 (rsp_out_word2),
      .rsp_out_size  (rsp_out_size),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   // with req_valid still high
   task automatic send_request(input op_type op, input entry_type item,
                               input logic [7:0] limit);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_key_word0  <= item.word0;
      req_key_word1  <= item.word1;
      req_key_word2  <= item.word2;
      req_group_size <= item.size;
      req_size_limit <= limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, item, limit);
      @(negedge clock);
   endtask

   initial begin : stimulus
      entry_type  name_pool[POOL_SIZE];
      entry_type  item;
      op_type     op;
      logic [7:0] limit;
      bit         filling;
      int         pick;
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_ADD;
      req_key_word0  = '0;
      req_key_word1  = '0;
      req_key_word2  = '0;
      req_group_size = '0;
      req_size_limit = '0;
      foreach (name_pool[i])
         name_pool[i] = {$urandom, $urandom, $urandom, $urandom, $urandom, 8'd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: every lookup gives none
      send_request(OP_LIST, '0, 8'd0);
      send_request(OP_SEARCH, '1, 8'd255);
      send_request(OP_REMOVE, '1, 8'd255);
      // extreme names and sizes, then a duplicate before the store is full
      send_request(OP_ADD, '0, 8'd255);
      send_request(OP_ADD, '1, 8'd0);
      send_request(OP_ADD, {160'd0, 8'd7}, 8'd0);
      // names that differ only past a zero byte
      send_request(OP_ADD, {64'h0000_0000_0042_0041, 64'd0, 32'd0, 8'd128}, 8'd0);
      send_request(OP_ADD, {64'h0000_0000_0000_0041, 64'd0, 32'd0, 8'd1}, 8'd0);
      for (int k = 0; k < DEPTH - 4; k++)
         send_request(OP_ADD, {$urandom, $urandom, $urandom, $urandom, $urandom,
                               8'(k + 2)}, 8'($urandom));
      // full store: new name is rejected, known name still reports duplicate
      send_request(OP_ADD, {$urandom, $urandom, $urandom, $urandom, $urandom, 8'd50},
                   8'd0);
      send_request(OP_ADD, {{160{1'b1}}, 8'd3}, 8'd0);
      send_request(OP_LIST, '1, 8'd0);
      send_request(OP_SEARCH, '0, 8'd0);
      send_request(OP_REMOVE, '0, 8'd0);
      send_request(OP_REMOVE, '0, 8'd0);
      send_request(OP_REMOVE, '0, 8'd255);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 78 : 0;
         rsp_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 37 : 0;
         if (phase == 2) begin
            // sender waits until the queue of expected responses runs dry
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(negedge clock);
            @(negedge clock);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 8)
               hold_rsp = 1'b1;
            // alternate between growing and shrinking the list
            filling = (((phase * PHASE_ITEMS + n) / 24) % 2) == 0;
            pick = $urandom_range(0, 9);
            if (filling)
               op = (pick < 7) ? OP_ADD : (pick == 7) ? OP_REMOVE :
                    (pick == 8) ? OP_LIST : OP_SEARCH;
            else
               op = (pick < 2) ? OP_ADD : (pick < 7) ? OP_REMOVE :
                    (pick == 7) ? OP_LIST : OP_SEARCH;
            item = {$urandom, $urandom, $urandom, $urandom, $urandom, 8'd0};
            if ($urandom_range(0, 1) == 1)
               item = name_pool[$urandom_range(0, POOL_SIZE - 1)];
            item.size = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) :
                        8'($urandom_range(0, 12));
            case ($urandom_range(0, 3))
               0:       limit = 8'd255;
               1:       limit = 8'd0;
               2:       limit = 8'($urandom);
               default: limit = 8'($urandom_range(0, 12));
            endcase
            send_request(op, item, limit);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : response_stall
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            // long hold-off so the block backs up onto the request side
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status,
                           {rsp_out_word0, rsp_out_word1, rsp_out_word2, rsp_out_size},
                           rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
